// ----- sv/gps_pkg.sv -----
// Package for the Goldbach pair search: shared types and constants.
package gps_pkg;

   localparam int unsigned SieveEntriesDefault = 1048576;
   localparam int unsigned CandWidth = 31;

   typedef enum logic [3:0] {
      ST_SIEVE_FILL,
      ST_SIEVE_NEXT_P,
      ST_SIEVE_CHECK_P,
      ST_SIEVE_MARK,
      ST_IDLE,
      ST_PAIR_START,
      ST_TEST_A,
      ST_TEST_B,
      ST_MAP_WAIT,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_DIV_NEXT,
      ST_PAIR_NEXT,
      ST_DONE
   } state_type;

endpackage

// ----- sv/goldbach_pair_search.sv -----
// Top level of the Goldbach pair search: sieve builder, pair walker and prime tester.

// After reset the block first fills its one-bit-per-number sieve memory with
// ones (zeros at entries 0 and 1), one entry per cycle, and then strikes out
// the composites with the sieve of Eratosthenes, one memory write per struck
// entry, plus a sieve read (issued in ST_SIEVE_NEXT_P, checked in
// ST_SIEVE_CHECK_P) for every base not above the square root of
// SIEVE_ENTRIES. No candidate is taken until this is done. Each candidate is
// then processed alone: the walker steps m1 = 3, 5, 7, ... and m2 = n - m1
// and stops at the first pair in which both are prime, or when m1 would pass
// m2. A number below SIEVE_ENTRIES is looked up in the sieve memory (read
// issued in ST_MAP_WAIT, registered data taken in ST_DIV_NEXT). A larger even
// number is not prime; a larger odd one is tested by trial division by 3 and
// then 6k-1, 6k+1 while the square of the divisor does not exceed it; each
// division is done by a shared restoring divider that retires one quotient
// bit per cycle. The time per candidate is therefore data dependent: it grows
// with the pairs walked and, for numbers above the sieve range, with the
// trial divisors up to their square root. The result transfer is held in
// an output register, and an odd candidate or one below six answers "not
// found" at once.
module goldbach_pair_search
   import gps_pkg::*;
#(
   parameter int unsigned SIEVE_ENTRIES = SieveEntriesDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CandWidth-1:0] req_candidate,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CandWidth-1:0] rsp_checked_number,
   output logic                 rsp_pair_found,
   output logic [29:0]          rsp_smaller_prime,
   output logic [CandWidth-1:0] rsp_larger_prime
);

   localparam int unsigned AddrWidth = $clog2(SIEVE_ENTRIES);
   localparam logic [63:0] Entries64 = 64'(SIEVE_ENTRIES);

   // The sieve memory: written and read once per cycle, read data registered.
   logic map_mem [SIEVE_ENTRIES];
   logic                 map_we;
   logic [AddrWidth-1:0] map_waddr;
   logic                 map_wdata;
   logic [AddrWidth-1:0] map_raddr;
   logic                 map_rdata_ff;

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rdata_ff <= map_mem[map_raddr];
   end

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;           // where a primality test returns
   logic [31:0] sp_ff, sp_in;           // sieve base
   logic [31:0] sq_ff, sq_in;           // sieve strike index
   logic [CandWidth-1:0] n_ff, n_in;
   logic [CandWidth-1:0] a_ff, a_in;
   logic [CandWidth-1:0] b_ff, b_in;
   logic [CandWidth-1:0] t_ff, t_in;    // number under test
   logic                 prime_ff, prime_in;
   logic [CandWidth-1:0] dv_ff, dv_in;  // trial divisor
   logic                 step4_ff, step4_in;
   logic [CandWidth-1:0] rem_ff, rem_in;
   logic [CandWidth-1:0] quo_ff, quo_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 rv_ff, rv_in;
   logic [CandWidth-1:0] r_num_ff, r_num_in;
   logic                 r_found_ff, r_found_in;
   logic [29:0]          r_lo_ff, r_lo_in;
   logic [CandWidth-1:0] r_hi_ff, r_hi_in;

   logic [CandWidth:0]   rem_shift;
   logic [63:0]          dv_sq;
   logic                 t_small;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SIEVE_FILL;
         rv_ff    <= 1'b0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         sp_ff    <= sp_in;
      end
      ret_ff     <= ret_in;
      sq_ff      <= sq_in;
      n_ff       <= n_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      t_ff       <= t_in;
      prime_ff   <= prime_in;
      dv_ff      <= dv_in;
      step4_ff   <= step4_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      r_num_ff   <= r_num_in;
      r_found_ff <= r_found_in;
      r_lo_ff    <= r_lo_in;
      r_hi_ff    <= r_hi_in;
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      sp_in      = sp_ff;
      sq_in      = sq_ff;
      n_in       = n_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      t_in       = t_ff;
      prime_in   = prime_ff;
      dv_in      = dv_ff;
      step4_in   = step4_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      rv_in      = rv_ff;
      r_num_in   = r_num_ff;
      r_found_in = r_found_ff;
      r_lo_in    = r_lo_ff;
      r_hi_in    = r_hi_ff;
      map_we     = 1'b0;
      map_waddr  = sq_ff[AddrWidth-1:0];
      map_wdata  = 1'b0;
      map_raddr  = sp_ff[AddrWidth-1:0];
      req_stall  = 1'b1;
      rem_shift  = {rem_ff, quo_ff[CandWidth-1]};
      dv_sq      = 64'(dv_ff) * 64'(dv_ff);
      t_small    = 64'(t_ff) < Entries64;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         ST_SIEVE_FILL: begin
            // sp counts the fill address; entries 0 and 1 are not prime.
            map_we    = 1'b1;
            map_waddr = sp_ff[AddrWidth-1:0];
            map_wdata = (sp_ff > 32'd1);
            sp_in     = sp_ff + 32'd1;
            if (64'(sp_ff) == Entries64 - 64'd1) begin
               sp_in    = 32'd2;
               state_in = ST_SIEVE_NEXT_P;
            end
         end
         ST_SIEVE_NEXT_P: begin
            if (64'(sp_ff) * 64'(sp_ff) > Entries64) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SIEVE_CHECK_P;   // read issued this cycle
            end
         end
         ST_SIEVE_CHECK_P: begin
            if (map_rdata_ff) begin
               sq_in    = 32'(64'(sp_ff) * 64'(sp_ff));
               state_in = ST_SIEVE_MARK;
            end else begin
               sp_in    = sp_ff + 32'd1;
               state_in = ST_SIEVE_NEXT_P;
            end
         end
         ST_SIEVE_MARK: begin
            if (64'(sq_ff) >= Entries64) begin
               sp_in    = sp_ff + 32'd1;
               state_in = ST_SIEVE_NEXT_P;
            end else begin
               map_we = 1'b1;
               sq_in  = sq_ff + sp_ff;
            end
         end
         ST_IDLE: begin
            req_stall = rv_ff;
            if (req_valid && !rv_ff) begin
               n_in     = req_candidate;
               state_in = ST_PAIR_START;
            end
         end
         ST_PAIR_START: begin
            r_found_in = 1'b0;
            r_lo_in    = '0;
            r_hi_in    = '0;
            if (n_ff[0] || n_ff < CandWidth'(6)) begin
               state_in = ST_DONE;
            end else begin
               a_in     = CandWidth'(3);
               b_in     = n_ff - CandWidth'(3);
               t_in     = CandWidth'(3);
               ret_in   = ST_TEST_A;
               state_in = ST_MAP_WAIT;
            end
         end
         ST_MAP_WAIT: begin
            // Issue a sieve read for a small number, else mark an even number not prime or start trial division.
            map_raddr = t_ff[AddrWidth-1:0];
            if (t_small) begin
               state_in = ST_DIV_NEXT;
               cnt_in   = '1;
            end else if (!t_ff[0]) begin
               prime_in = 1'b0;
               state_in = ret_ff;
            end else begin
               dv_in    = CandWidth'(3);
               step4_in = 1'b0;
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_NEXT: begin
            // Registered sieve data is valid here.
            prime_in = map_rdata_ff;
            state_in = ret_ff;
         end
         ST_DIV_INIT: begin
            if (dv_sq > 64'(t_ff)) begin
               prime_in = 1'b1;
               state_in = ret_ff;
            end else begin
               rem_in   = '0;
               quo_in   = t_ff;
               cnt_in   = 6'(CandWidth);
               state_in = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            // One restoring quotient bit per cycle.
            quo_in = {quo_ff[CandWidth-2:0], 1'b0};
            if (rem_shift >= {1'b0, dv_ff}) begin
               rem_in    = CandWidth'(rem_shift - {1'b0, dv_ff});
               quo_in[0] = 1'b1;
            end else begin
               rem_in = rem_shift[CandWidth-1:0];
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = ST_TEST_B;
               ret_in   = ret_ff;
            end
            if (cnt_ff == 6'd1) begin
               state_in = ST_PAIR_NEXT;
            end
         end
         ST_PAIR_NEXT: begin
            if (state_ff == ST_PAIR_NEXT && cnt_ff == 6'd0 && !t_small
                  && dv_ff != '0) begin
               if (rem_ff == '0) begin
                  prime_in = 1'b0;
                  state_in = ret_ff;
               end else begin
                  if (dv_ff == CandWidth'(3)) begin
                     dv_in    = CandWidth'(5);
                     step4_in = 1'b0;
                  end else begin
                     dv_in    = dv_ff + (step4_ff ? CandWidth'(4) : CandWidth'(2));
                     step4_in = !step4_ff;
                  end
                  state_in = ST_DIV_INIT;
               end
            end
         end
         ST_TEST_A: begin
            if (prime_ff) begin
               t_in     = b_ff;
               ret_in   = ST_TEST_B;
               state_in = ST_MAP_WAIT;
            end else begin
               state_in = ST_IDLE;
               a_in     = a_ff + CandWidth'(2);
               b_in     = b_ff - CandWidth'(2);
               state_in = (a_ff + CandWidth'(2) <= b_ff - CandWidth'(2))
                          ? ST_MAP_WAIT : ST_DONE;
               t_in     = a_ff + CandWidth'(2);
               ret_in   = ST_TEST_A;
            end
         end
         ST_TEST_B: begin
            if (prime_ff) begin
               r_found_in = 1'b1;
               r_lo_in    = a_ff[29:0];
               r_hi_in    = b_ff;
               state_in   = ST_DONE;
            end else begin
               a_in     = a_ff + CandWidth'(2);
               b_in     = b_ff - CandWidth'(2);
               state_in = (a_ff + CandWidth'(2) <= b_ff - CandWidth'(2))
                          ? ST_MAP_WAIT : ST_DONE;
               t_in     = a_ff + CandWidth'(2);
               ret_in   = ST_TEST_A;
            end
         end
         ST_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               r_num_in = n_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rv_ff;
   assign rsp_checked_number = r_num_ff;
   assign rsp_pair_found     = r_found_ff;
   assign rsp_smaller_prime  = r_lo_ff;
   assign rsp_larger_prime   = r_hi_ff;

   // A found pair always sums to the echoed candidate.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_found |->
         (CandWidth'(rsp_smaller_prime) + rsp_larger_prime) == rsp_checked_number)
      else $error("pair does not sum to candidate");

   // Not found reports zero primes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pair_found |->
         rsp_smaller_prime == '0 && rsp_larger_prime == '0)
      else $error("not found with nonzero primes");

   // No candidate is taken while the sieve is being filled or composites are being struck out.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIEVE_FILL || state_ff == ST_SIEVE_MARK) |-> req_stall)
      else $error("input taken during sieve build");

   // The divider stays within its bit count.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_RUN |-> cnt_ff != 6'd0)
      else $error("divider counter underflow");

endmodule
